[hw/rtl/drt_pkg.sv]
// types, codes and date helpers for the dated record table
package drt_pkg;

  localparam int OP_W     = 2;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int LABEL_W  = 64;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int CENT_W   = 6;
  localparam int BYTES    = LABEL_W / 8;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_EDIT   = 2'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_DATE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 12'd1000;
  localparam logic [YEAR_W-1:0]  YEAR_END  = 12'd3000;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;

  // floor(y / 100) as (y * 5243) >> 19, exact for every 12-bit year
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = 25'd5243;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [YEAR_W-1:0]  rec_year;
    logic [MONTH_W-1:0] rec_month;
    logic [DAY_W-1:0]   rec_day;
    logic [LABEL_W-1:0] rec_label;
    logic [YEAR_W-1:0]  new_year;
    logic [MONTH_W-1:0] new_month;
    logic [DAY_W-1:0]   new_day;
    logic [LABEL_W-1:0] new_label;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [YEAR_W-1:0]   found_year;
    logic [MONTH_W-1:0]  found_month;
    logic [DAY_W-1:0]    found_day;
  } res_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [LABEL_W-1:0] label;
  } rec_t;

  // clear every byte above the first zero byte
  function automatic logic [LABEL_W-1:0] norm_label(input logic [LABEL_W-1:0] v);
    logic [LABEL_W-1:0] r;
    logic               stop;
    r    = '0;
    stop = 1'b0;
    for (int b = 0; b < BYTES; b++) begin
      if (v[8*b +: 8] == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        r[8*b +: 8] = v[8*b +: 8];
      end
    end
    return r;
  endfunction

  function automatic logic [CENT_W-1:0] century(input logic [YEAR_W-1:0] y);
    logic [RECIP_W-1:0] p;
    p = RECIP_W'(y) * RECIP_100;
    return p[RECIP_SHIFT +: CENT_W];
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] n;
    case (m)
      4'd2:                   n = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                n = 5'd31;
    endcase
    return n;
  endfunction

  // cent is the registered floor(y / 100)
  function automatic logic date_ok(input logic [YEAR_W-1:0]  y,
                                   input logic [MONTH_W-1:0] m,
                                   input logic [DAY_W-1:0]   d,
                                   input logic [CENT_W-1:0]  cent);
    logic [YEAR_W-1:0] base;
    logic              leap;
    logic [DAY_W-1:0]  lim;
    base = YEAR_W'(YEAR_W'(cent) * YEAR_W'(100));
    leap = ((y[1:0] == 2'd0) && (y != base)) || ((y == base) && (cent[1:0] == 2'd0));
    lim  = month_len(m) + DAY_W'((m == MONTH_FEB) && leap);
    return (y >= YEAR_MIN) && (y < YEAR_END) && (m != '0) && (m <= MONTH_MAX) &&
           (d != '0) && (d <= lim);
  endfunction

endpackage

[hw/rtl/drt_ifs.sv]
// command and result channel interfaces of the dated record table
interface drt_cmd_if;
  import drt_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface drt_res_if;
  import drt_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/dated_record_table.sv]
// dated record table: add, search, edit and delete over a record memory
//
// cmd carries one command item (op, key date and name, replacement date and
// name); res returns exactly one result item per command (status, slot and
// the date found by a search). Both use valid/ready; an item moves at a
// rising edge with valid and ready high.
//
// A command is taken only while the block is idle. It then works out the
// century quotient of both years (S_YEAR), checks the dates (S_DATE), and
// scans the record memory one entry per cycle through its single registered
// read port, stopping at the first hit. S_ACT then acts on the scan result
// (the write-back on a hit) and S_DONE loads the output register once it is
// free. A command whose key date is bad (any op but search) skips the scan;
// otherwise the scan length sets how long a command takes.
//
// Reset empties the table at once: a valid bit per entry makes an entry never
// written read as a free slot. No clearing pass is needed.
// The result stays in the output register until taken; while it waits the
// next command may already be accepted and worked on up to its result.
module dated_record_table #(
  parameter int ENTRIES = 16
) (
  input logic    clk,
  input logic    rst,
  drt_cmd_if.sink   cmd,
  drt_res_if.source res
);
  import drt_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_YEAR = 3'd1;
  localparam logic [2:0] S_DATE = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_ACT  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]        state;
  cmd_t              cmd_in;
  cmd_t              cmd_q;
  logic [CENT_W-1:0] cent_rec;
  logic [CENT_W-1:0] cent_new;
  logic              new_ok;
  logic              rec_ok;
  logic [CW-1:0]     issue;
  logic              rd_live;
  logic [IW-1:0]     rd_idx;
  logic [IW-1:0]     rd_addr;
  rec_t              rd_raw;
  logic              rd_vld;
  rec_t              rd_cur;
  logic              hit_now;
  logic              found;
  logic [IW-1:0]     hit_idx;
  rec_t              hit_rec;
  res_t              pend;
  res_t              pend_next;
  logic              out_valid;
  res_t              out_data;
  logic              wr_en;
  rec_t              wr_rec;
  logic [IW+SLOT_W-1:0] slot_ext;

  rec_t              mem [ENTRIES];
  logic [ENTRIES-1:0] vld;

  assign cmd.ready = (state == S_IDLE);
  assign res.valid = out_valid;
  assign res.data  = out_data;

  assign rd_addr = issue[IW-1:0];
  assign rd_cur  = rd_vld ? rd_raw : '0;
  assign rec_ok  = date_ok(cmd_q.rec_year, cmd_q.rec_month, cmd_q.rec_day, cent_rec);

  // incoming command with both names trimmed
  always_comb begin
    cmd_in           = cmd.data;
    cmd_in.rec_label = norm_label(cmd.data.rec_label);
    cmd_in.new_label = norm_label(cmd.data.new_label);
  end

  always_comb begin
    case (cmd_q.op)
      OP_ADD:    hit_now = (rd_cur.year == '0);
      OP_SEARCH: hit_now = (rd_cur.year != '0) && (rd_cur.label == cmd_q.rec_label);
      default:   hit_now = (rd_cur.year != '0) && (rd_cur.year == cmd_q.rec_year) &&
                           (rd_cur.month == cmd_q.rec_month) &&
                           (rd_cur.day == cmd_q.rec_day) &&
                           (rd_cur.label == cmd_q.rec_label);
    endcase
  end

  // write-back of the hit entry
  always_comb begin
    wr_en  = (state == S_ACT) && found && (cmd_q.op != OP_SEARCH) &&
             !((cmd_q.op == OP_EDIT) && !new_ok);
    case (cmd_q.op)
      OP_ADD:  wr_rec = '{cmd_q.rec_year, cmd_q.rec_month, cmd_q.rec_day, cmd_q.rec_label};
      OP_EDIT: wr_rec = '{cmd_q.new_year, cmd_q.new_month, cmd_q.new_day, cmd_q.new_label};
      default: wr_rec = '0;
    endcase
  end

  assign slot_ext = {{SLOT_W{1'b0}}, hit_idx};

  always_comb begin
    pend_next = '0;
    if (!found) begin
      pend_next.status = (cmd_q.op == OP_ADD) ? ST_FULL : ST_NOT_FOUND;
    end else if ((cmd_q.op == OP_EDIT) && !new_ok) begin
      pend_next.status = ST_BAD_DATE;
    end else begin
      pend_next.status = ST_DONE;
      pend_next.slot   = slot_ext[SLOT_W-1:0];
      if (cmd_q.op == OP_SEARCH) begin
        pend_next.found_year  = hit_rec.year;
        pend_next.found_month = hit_rec.month;
        pend_next.found_day   = hit_rec.day;
      end
    end
  end

  // record memory, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[hit_idx] <= wr_rec;
    end
    rd_raw <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[hit_idx] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_live   <= 1'b0;
      issue     <= '0;
      found     <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid && res.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      rd_live <= (state == S_SCAN) && (issue < CW'(ENTRIES));
      rd_idx  <= rd_addr;
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            cmd_q <= cmd_in;
            state <= S_YEAR;
          end
        end
        S_YEAR: begin
          cent_rec <= century(cmd_q.rec_year);
          cent_new <= century(cmd_q.new_year);
          state    <= S_DATE;
        end
        S_DATE: begin
          new_ok <= date_ok(cmd_q.new_year, cmd_q.new_month, cmd_q.new_day, cent_new);
          issue  <= '0;
          found  <= 1'b0;
          if ((cmd_q.op != OP_SEARCH) && !rec_ok) begin
            pend  <= '{status: ST_BAD_DATE, default: '0};
            state <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue < CW'(ENTRIES)) begin
            issue <= issue + CW'(1);
          end
          if (rd_live && hit_now) begin
            found   <= 1'b1;
            hit_idx <= rd_idx;
            hit_rec <= rd_cur;
            state   <= S_ACT;
          end else if (!rd_live && (issue == CW'(ENTRIES))) begin
            state <= S_ACT;
          end
        end
        S_ACT: begin
          pend  <= pend_next;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || res.ready) begin
            out_valid <= 1'b1;
            out_data  <= pend;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_full_only_add: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACT) && !found && (pend_next.status == ST_FULL) |-> cmd_q.op == OP_ADD)
    else $error("full reported for an op other than add");

  a_write_needs_hit: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> found && (state == S_ACT))
    else $error("memory write without a hit entry");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    issue <= CW'(ENTRIES))
    else $error("scan counter ran past the table");

  a_result_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_DONE) |->
      (out_data.slot == '0) && (out_data.found_year == '0))
    else $error("failed command reports a slot or date");

  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.ready |=> out_valid && $stable(out_data))
    else $error("waiting result was overwritten");

endmodule
